// ===== hw/rtl/tpd_pkg.sv =====
// Shared types and constants for the trajectory point decimator.
// No dependencies.
package tpd_pkg;

   typedef enum logic [1:0] {
      ACT_FIRST   = 2'd0,
      ACT_APPEND  = 2'd1,
      ACT_REPLACE = 2'd2,
      ACT_DROP    = 2'd3
   } action_type;

   localparam int AXES = 3;
   localparam int STEP_WIDTH = 16;
   localparam logic [STEP_WIDTH-1:0] MIN_STEP_RESET = 16'd66;

endpackage

// ===== hw/rtl/tpd_step.sv =====
// Combinational decision for one point: squared distance test, action and box widening.
// Depends on tpd_pkg.
module tpd_step #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          have_point,
   input  logic signed [COORD_WIDTH-1:0] pos [tpd_pkg::AXES],
   input  logic [1:0]                    conf,
   input  logic signed [COORD_WIDTH-1:0] last_pos [tpd_pkg::AXES],
   input  logic [1:0]                    last_conf,
   input  logic [2*tpd_pkg::STEP_WIDTH-1:0] thr,
   input  logic signed [COORD_WIDTH-1:0] min_c [tpd_pkg::AXES],
   input  logic signed [COORD_WIDTH-1:0] max_c [tpd_pkg::AXES],
   output tpd_pkg::action_type           action,
   output logic                          keep,
   output logic signed [COORD_WIDTH-1:0] next_min [tpd_pkg::AXES],
   output logic signed [COORD_WIDTH-1:0] next_max [tpd_pkg::AXES]
);

   localparam int SW = tpd_pkg::STEP_WIDTH;

   logic signed [COORD_WIDTH:0]   diff [tpd_pkg::AXES];
   logic [COORD_WIDTH:0]          mag  [tpd_pkg::AXES];
   logic [tpd_pkg::AXES-1:0]      near;
   logic [2*SW-1:0]               sq   [tpd_pkg::AXES];
   logic [2*SW+1:0]               dist2;
   logic                          close;

   // Any axis at or beyond 2^16 apart is already past every threshold.
   always_comb begin
      for (int i = 0; i < tpd_pkg::AXES; i++) begin
         diff[i] = {pos[i][COORD_WIDTH-1], pos[i]} - {last_pos[i][COORD_WIDTH-1], last_pos[i]};
         mag[i]  = diff[i][COORD_WIDTH] ? (COORD_WIDTH+1)'(-diff[i])
                                        : (COORD_WIDTH+1)'(diff[i]);
         near[i] = (mag[i][COORD_WIDTH:SW] == '0);
         sq[i]   = mag[i][SW-1:0] * mag[i][SW-1:0];
      end
      dist2 = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
      close = (&near) && (dist2 < {2'b00, thr});
   end

   always_comb begin
      if (!have_point) begin
         action = tpd_pkg::ACT_FIRST;
      end else if (close) begin
         action = (conf > last_conf) ? tpd_pkg::ACT_REPLACE : tpd_pkg::ACT_DROP;
      end else begin
         action = tpd_pkg::ACT_APPEND;
      end
      keep = (action != tpd_pkg::ACT_DROP);
   end

   always_comb begin
      for (int i = 0; i < tpd_pkg::AXES; i++) begin
         if (!have_point) begin
            next_min[i] = pos[i];
            next_max[i] = pos[i];
         end else begin
            next_min[i] = (pos[i] < min_c[i]) ? pos[i] : min_c[i];
            next_max[i] = (pos[i] > max_c[i]) ? pos[i] : max_c[i];
         end
      end
   end

endmodule

// ===== hw/rtl/trajectory_point_decimator.sv =====
// Trajectory point decimator top level: input register, decision step, kept point and box.
// Depends on tpd_pkg and tpd_step.
//
//   port group   dir   flow control      beat contents
//   req_*        in    valid / stall     pos_x, pos_y, pos_z, confidence
//   rsp_*        out   valid / stall     action, kept point, kept confidence, box
//   csr_*        in    valid / ready     min_step
//
// One beat per cycle unless rsp stalls; req beats go via the input and rsp registers.
// The decision for a point uses the kept point left by the one before it,
// so the step logic closes a loop through the kept-point registers.
// Synchronous active-high reset; min_step returns to 66.
// A stalled rsp holds the input register one more beat, then stalls req.
module trajectory_point_decimator #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic [1:0]                    req_confidence,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_action,
   output logic signed [COORD_WIDTH-1:0] rsp_kept_x,
   output logic signed [COORD_WIDTH-1:0] rsp_kept_y,
   output logic signed [COORD_WIDTH-1:0] rsp_kept_z,
   output logic [1:0]                    rsp_kept_confidence,
   output logic signed [COORD_WIDTH-1:0] rsp_box_min_x,
   output logic signed [COORD_WIDTH-1:0] rsp_box_min_y,
   output logic signed [COORD_WIDTH-1:0] rsp_box_min_z,
   output logic signed [COORD_WIDTH-1:0] rsp_box_max_x,
   output logic signed [COORD_WIDTH-1:0] rsp_box_max_y,
   output logic signed [COORD_WIDTH-1:0] rsp_box_max_z,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tpd_pkg::STEP_WIDTH-1:0] csr_min_step
);

   localparam int TW = 2 * tpd_pkg::STEP_WIDTH;
   localparam logic [TW-1:0] THR_RESET =
      TW'(tpd_pkg::MIN_STEP_RESET) * TW'(tpd_pkg::MIN_STEP_RESET);

   logic                          in_valid_ff, in_valid_in;
   logic signed [COORD_WIDTH-1:0] in_pos_ff [tpd_pkg::AXES];
   logic [1:0]                    in_conf_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   tpd_pkg::action_type           action_ff;
   logic [TW-1:0]                 thr_ff;
   logic                          have_point_ff;
   logic signed [COORD_WIDTH-1:0] last_pos_ff [tpd_pkg::AXES];
   logic [1:0]                    last_conf_ff;
   logic signed [COORD_WIDTH-1:0] min_c_ff [tpd_pkg::AXES];
   logic signed [COORD_WIDTH-1:0] max_c_ff [tpd_pkg::AXES];

   tpd_pkg::action_type           step_action;
   logic                          step_keep;
   logic signed [COORD_WIDTH-1:0] next_min [tpd_pkg::AXES];
   logic signed [COORD_WIDTH-1:0] next_max [tpd_pkg::AXES];
   logic                          req_take;
   logic                          advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   tpd_step #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_step (
      .have_point(have_point_ff),
      .pos       (in_pos_ff),
      .conf      (in_conf_ff),
      .last_pos  (last_pos_ff),
      .last_conf (last_conf_ff),
      .thr       (thr_ff),
      .min_c     (min_c_ff),
      .max_c     (max_c_ff),
      .action    (step_action),
      .keep      (step_keep),
      .next_min  (next_min),
      .next_max  (next_max)
   );

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pos_ff[0] <= req_pos_x;
         in_pos_ff[1] <= req_pos_y;
         in_pos_ff[2] <= req_pos_z;
         in_conf_ff   <= req_confidence;
      end
      if (advance) begin
         action_ff <= step_action;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         thr_ff        <= THR_RESET;
         have_point_ff <= 1'b0;
         last_conf_ff  <= 2'd0;
         for (int i = 0; i < tpd_pkg::AXES; i++) begin
            last_pos_ff[i] <= '0;
            min_c_ff[i]    <= '0;
            max_c_ff[i]    <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= TW'(csr_min_step) * TW'(csr_min_step);
         end
         if (advance && step_keep) begin
            have_point_ff <= 1'b1;
            last_conf_ff  <= in_conf_ff;
            for (int i = 0; i < tpd_pkg::AXES; i++) begin
               last_pos_ff[i] <= in_pos_ff[i];
               min_c_ff[i]    <= next_min[i];
               max_c_ff[i]    <= next_max[i];
            end
         end
      end
   end

   // state only moves on a rsp load, so it doubles as the rsp payload
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action          = action_ff;
   assign rsp_kept_x          = last_pos_ff[0];
   assign rsp_kept_y          = last_pos_ff[1];
   assign rsp_kept_z          = last_pos_ff[2];
   assign rsp_kept_confidence = last_conf_ff;
   assign rsp_box_min_x       = min_c_ff[0];
   assign rsp_box_min_y       = min_c_ff[1];
   assign rsp_box_min_z       = min_c_ff[2];
   assign rsp_box_max_x       = max_c_ff[0];
   assign rsp_box_max_y       = max_c_ff[1];
   assign rsp_box_max_z       = max_c_ff[2];

   a_rsp_after_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> have_point_ff)
      else $error("rsp beat without a kept point");

   a_box_holds_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (min_c_ff[0] <= last_pos_ff[0]) && (last_pos_ff[0] <= max_c_ff[0]) &&
                       (min_c_ff[1] <= last_pos_ff[1]) && (last_pos_ff[1] <= max_c_ff[1]) &&
                       (min_c_ff[2] <= last_pos_ff[2]) && (last_pos_ff[2] <= max_c_ff[2]))
      else $error("kept point outside box");

   a_first_seeds_box: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && action_ff == tpd_pkg::ACT_FIRST) |->
         (min_c_ff[0] == max_c_ff[0]) && (min_c_ff[1] == max_c_ff[1]) &&
         (min_c_ff[2] == max_c_ff[2]))
      else $error("first point did not seed a point box");

   a_drop_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (advance && step_action == tpd_pkg::ACT_DROP) |=>
         $stable(last_conf_ff) && $stable(last_pos_ff[0]) &&
         $stable(last_pos_ff[1]) && $stable(last_pos_ff[2]))
      else $error("dropped point changed kept point");

   a_first_only_once: assert property (@(posedge clock) disable iff (reset)
      (advance && have_point_ff) |-> step_action != tpd_pkg::ACT_FIRST)
      else $error("second first point");

endmodule
